// ===== hdl/cpmd_pkg.sv =====
// ----------------------------------------------------------------------------
// Closest pair package
// Shared sizes, controller states and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package cpmd_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_BITS   = $clog2(MAX_POINTS);
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int COORD_BITS = 16;
  localparam int SQ_BITS    = 33;
  localparam int BEST_BITS  = SQ_BITS + 1;
  localparam int Q8_BITS    = 25;
  localparam int RAD_BITS   = 2 * Q8_BITS;
  localparam int REM_BITS   = Q8_BITS + 2;
  localparam int STEP_BITS  = $clog2(Q8_BITS);

  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_ROOT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                wr_en;
    logic [IDX_BITS-1:0] wr_addr;
    logic                pair_vld;
    logic [IDX_BITS-1:0] rd_i;
    logic [IDX_BITS-1:0] rd_j;
    logic                best_clr;
    logic                root_load;
    logic                root_step;
    logic                res_vld;
    logic                no_pair;
    logic                overflow;
  } cmd_t;

  typedef struct packed {
    logic pipe_empty;
  } stat_t;

endpackage

// ===== hdl/cpmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Closest pair controller
// Counts loaded points, walks every index pair of the loaded points, waits for
// the distance pipeline to drain and sequences the square root steps.
// ----------------------------------------------------------------------------
module cpmd_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        in_last_point,
  output logic                        busy,
  output cpmd_pkg::cmd_t              cmd,
  input  cpmd_pkg::stat_t             stat
);

  cpmd_pkg::state_t                 state_r, state_nxt;
  logic [cpmd_pkg::CNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic                             ovf_r, ovf_nxt;
  logic [cpmd_pkg::IDX_BITS-1:0]    i_r, i_nxt;
  logic [cpmd_pkg::IDX_BITS-1:0]    j_r, j_nxt;
  logic [cpmd_pkg::STEP_BITS-1:0]   step_r, step_nxt;
  logic                             accept;
  logic                             room;
  logic [cpmd_pkg::CNT_BITS-1:0]    cnt_after;
  logic                             j_end;
  logic                             i_end;

  assign accept    = start && (state_r == cpmd_pkg::S_LOAD);
  assign room      = cnt_r < cpmd_pkg::CNT_BITS'(cpmd_pkg::MAX_POINTS);
  assign cnt_after = room ? cnt_r + 1'b1 : cnt_r;
  assign j_end     = {1'b0, j_r} == cnt_r - 1'b1;
  assign i_end     = {1'b0, i_r} == cnt_r - 2'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpmd_pkg::S_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cpmd_pkg::S_LOAD: begin
        if (accept && in_last_point) begin
          state_nxt = (cnt_after < 2'd2) ? cpmd_pkg::S_DONE : cpmd_pkg::S_SCAN;
        end
      end
      cpmd_pkg::S_SCAN: begin
        if (j_end && i_end) begin
          state_nxt = cpmd_pkg::S_DRAIN;
        end
      end
      cpmd_pkg::S_DRAIN: begin
        if (stat.pipe_empty) begin
          state_nxt = cpmd_pkg::S_ROOT;
        end
      end
      cpmd_pkg::S_ROOT: begin
        if (step_r == cpmd_pkg::STEP_BITS'(cpmd_pkg::Q8_BITS - 1)) begin
          state_nxt = cpmd_pkg::S_DONE;
        end
      end
      cpmd_pkg::S_DONE: begin
        state_nxt = cpmd_pkg::S_LOAD;
      end
      default: begin
        state_nxt = cpmd_pkg::S_LOAD;
      end
    endcase
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    step_nxt = step_r;
    case (state_r)
      cpmd_pkg::S_LOAD: begin
        if (accept) begin
          cnt_nxt = cnt_after;
          if (!room) begin
            ovf_nxt = 1'b1;
          end
          i_nxt = '0;
          j_nxt = cpmd_pkg::IDX_BITS'(1);
        end
      end
      cpmd_pkg::S_SCAN: begin
        if (j_end) begin
          i_nxt = i_r + 1'b1;
          j_nxt = i_r + 2'd2;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      cpmd_pkg::S_DRAIN: begin
        step_nxt = '0;
      end
      cpmd_pkg::S_ROOT: begin
        step_nxt = step_r + 1'b1;
      end
      cpmd_pkg::S_DONE: begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_comb begin
    busy          = state_r != cpmd_pkg::S_LOAD;
    cmd           = '0;
    cmd.wr_addr   = cnt_r[cpmd_pkg::IDX_BITS-1:0];
    cmd.rd_i      = i_r;
    cmd.rd_j      = j_r;
    cmd.no_pair   = cnt_r < 2'd2;
    cmd.overflow  = ovf_r;
    case (state_r)
      cpmd_pkg::S_LOAD: begin
        cmd.wr_en    = accept && room;
        cmd.best_clr = accept && in_last_point;
      end
      cpmd_pkg::S_SCAN: begin
        cmd.pair_vld = 1'b1;
      end
      cpmd_pkg::S_DRAIN: begin
        cmd.root_load = stat.pipe_empty;
      end
      cpmd_pkg::S_ROOT: begin
        cmd.root_step = 1'b1;
      end
      cpmd_pkg::S_DONE: begin
        cmd.res_vld = 1'b1;
      end
      default: begin
        cmd.res_vld = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/cpmd_dp.sv =====
// ----------------------------------------------------------------------------
// Closest pair datapath
// Point store with two read ports, a pipelined squared distance unit with a
// running minimum, and a bit-pair square root unit for the Q8 result.
// ----------------------------------------------------------------------------
module cpmd_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [cpmd_pkg::COORD_BITS-1:0] in_point_x,
  input  logic signed [cpmd_pkg::COORD_BITS-1:0] in_point_y,
  input  cpmd_pkg::cmd_t                    cmd,
  output cpmd_pkg::stat_t                   stat,
  output logic                              out_valid,
  output logic [cpmd_pkg::SQ_BITS-1:0]      out_min_dist_sq,
  output logic [cpmd_pkg::Q8_BITS-1:0]      out_min_dist_q8,
  output logic                              out_no_pair,
  output logic                              out_overflow
);

  localparam int CB = cpmd_pkg::COORD_BITS;

  logic [2*CB-1:0]                  mem [cpmd_pkg::MAX_POINTS];
  logic [2*CB-1:0]                  rd_a_r, rd_b_r;
  logic                             v1_r, v2_r, v3_r;
  logic signed [CB:0]               dx, dy;
  logic [CB-1:0]                    adx_r, ady_r;
  logic [2*CB-1:0]                  sqx_r, sqy_r;
  logic [cpmd_pkg::SQ_BITS-1:0]     sum;
  logic [cpmd_pkg::BEST_BITS-1:0]   best_r;
  logic [cpmd_pkg::RAD_BITS-1:0]    rad_r;
  logic [cpmd_pkg::REM_BITS-1:0]    rem_r;
  logic [cpmd_pkg::Q8_BITS-1:0]     root_r;
  logic [cpmd_pkg::REM_BITS-1:0]    rem_sh;
  logic [cpmd_pkg::REM_BITS-1:0]    trial;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= {in_point_x, in_point_y};
    end
    rd_a_r <= mem[cmd.rd_i];
    rd_b_r <= mem[cmd.rd_j];
  end

  always_comb begin
    dx = {rd_a_r[2*CB-1], rd_a_r[2*CB-1:CB]} - {rd_b_r[2*CB-1], rd_b_r[2*CB-1:CB]};
    dy = {rd_a_r[CB-1], rd_a_r[CB-1:0]} - {rd_b_r[CB-1], rd_b_r[CB-1:0]};
    sum = {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  always_ff @(posedge clk) begin
    adx_r <= dx[CB] ? CB'(-dx) : dx[CB-1:0];
    ady_r <= dy[CB] ? CB'(-dy) : dy[CB-1:0];
    sqx_r <= adx_r * adx_r;
    sqy_r <= ady_r * ady_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      best_r <= '1;
    end else begin
      v1_r <= cmd.pair_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.best_clr) begin
        best_r <= '1;
      end else if (v3_r && ({1'b0, sum} < best_r)) begin
        best_r <= {1'b0, sum};
      end
    end
  end

  assign stat.pipe_empty = !(v1_r || v2_r || v3_r);

  always_comb begin
    rem_sh = {rem_r[cpmd_pkg::REM_BITS-3:0], rad_r[cpmd_pkg::RAD_BITS-1 -: 2]};
    trial  = {root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (cmd.root_load) begin
      rad_r  <= {1'b0, best_r[cpmd_pkg::SQ_BITS-1:0], 16'd0};
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.root_step) begin
      rad_r <= {rad_r[cpmd_pkg::RAD_BITS-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[cpmd_pkg::Q8_BITS-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[cpmd_pkg::Q8_BITS-2:0], 1'b0};
      end
    end
  end

  assign out_valid       = cmd.res_vld;
  assign out_no_pair     = cmd.no_pair;
  assign out_overflow    = cmd.overflow;
  assign out_min_dist_sq = cmd.no_pair ? '0 : best_r[cpmd_pkg::SQ_BITS-1:0];
  assign out_min_dist_q8 = cmd.no_pair ? '0 : root_r;

endmodule

// ===== hdl/closest_pair_min_distance.sv =====
// ----------------------------------------------------------------------------
// Closest pair minimum distance
// Loads up to 64 points, then reports the smallest squared distance between
// any two of them and its square root in unsigned Q8.
// Sequence: a point beat without the last flag just stores the point; after the
// last beat with N >= 2 points, the one-pair-per-cycle scan, a pipeline drain
// and the 25-step square root precede the result; for N < 2 it is the next cycle.
// Throughput: one set at a time; busy stays high from the last beat to the
// result strobe. Reset (rst_n low, synchronous) empties the set.
// ----------------------------------------------------------------------------
module closest_pair_min_distance (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [cpmd_pkg::COORD_BITS-1:0] in_point_x,
  input  logic signed [cpmd_pkg::COORD_BITS-1:0] in_point_y,
  input  logic                                   in_last_point,
  output logic                                   out_valid,
  output logic [cpmd_pkg::SQ_BITS-1:0]           out_min_dist_sq,
  output logic [cpmd_pkg::Q8_BITS-1:0]           out_min_dist_q8,
  output logic                                   out_no_pair,
  output logic                                   out_overflow
);

  cpmd_pkg::cmd_t  cmd;
  cpmd_pkg::stat_t stat;

  cpmd_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_last_point (in_last_point),
    .busy          (busy),
    .cmd           (cmd),
    .stat          (stat)
  );

  cpmd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_min_dist_sq (out_min_dist_sq),
    .out_min_dist_q8 (out_min_dist_q8),
    .out_no_pair     (out_no_pair),
    .out_overflow    (out_overflow)
  );

endmodule
